/* rtl/core/pid_temperature_controller_defines.svh */
// Assertion macros used by the top RTL file of the temperature controller.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef PID_TEMPERATURE_CONTROLLER_DEFINES_SVH
`define PID_TEMPERATURE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptc assertion failed");
`define PTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptc assertion failed");
`else
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/ptc_pkg.sv */
`default_nettype none

package ptc_pkg;

    localparam int PW = 66;
    localparam int YW = 16;
    localparam int DW = 36;
    localparam int QW = 38;

    localparam int P_SCALE     = 1000;
    localparam int I_SCALE     = 1000000;
    localparam int LIMIT_RESET = 15000;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 21;

    localparam logic [CFG_IW-1:0] CFG_SETPOINT = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GAIN_P   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_GAIN_I   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_GAIN_D   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_WINDOW   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LIMIT    = 3'd5;

    typedef struct packed {
        logic signed [20:0] measured_temp;
        logic        [15:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               in_window;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic clr;
        logic sub;
    } t_mul_ctl;

endpackage

`default_nettype wire

/* rtl/core/ptc_mul.sv */
`default_nettype none

// Shift-and-add multiplier: one multiplier bit per cycle, optional subtract.
module ptc_mul (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire ptc_pkg::t_mul_ctl        i_ctl,
    input  wire logic [ptc_pkg::PW-1:0]   i_mcand,
    input  wire logic [ptc_pkg::YW-1:0]   i_mplier,
    output logic      [ptc_pkg::PW-1:0]   o_prod,
    output logic                          o_busy
);

    logic [ptc_pkg::PW-1:0] r_mcand;
    logic [ptc_pkg::PW-1:0] r_prod;
    logic [ptc_pkg::YW-1:0] r_mplier;
    logic                   r_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
        end else if (i_ctl.load) begin
            r_mplier <= i_mplier;
        end else begin
            r_mplier <= r_mplier >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_mcand;
            r_sub   <= i_ctl.sub;
            if (i_ctl.clr) begin
                r_prod <= '0;
            end
        end else begin
            r_mcand <= r_mcand << 1;
            if (r_mplier[0]) begin
                r_prod <= r_sub ? (r_prod - r_mcand) : (r_prod + r_mcand);
            end
        end
    end

    assign o_prod = r_prod;
    assign o_busy = |r_mplier;

endmodule

`default_nettype wire

/* rtl/core/ptc_div.sv */
`default_nettype none

// Restoring divider: signed dividend, unsigned divisor, one quotient bit per
// cycle. The quotient magnitude must fit in QW bits.
module ptc_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [ptc_pkg::PW-1:0]   i_num,
    input  wire logic [ptc_pkg::DW-1:0]   i_den,
    output logic      [ptc_pkg::QW-1:0]   o_quo,
    output logic                          o_neg,
    output logic                          o_busy
);

    localparam int CW = $clog2(ptc_pkg::QW + 1);
    localparam int HW = ptc_pkg::PW - ptc_pkg::QW;

    logic [CW-1:0]            r_cnt;
    logic [ptc_pkg::DW-1:0]   r_rem;
    logic [ptc_pkg::QW-1:0]   r_quo;
    logic                     r_neg;
    logic [ptc_pkg::PW-1:0]   w_mag;
    logic [ptc_pkg::DW:0]     w_trial;
    logic [ptc_pkg::DW:0]     w_diff;
    logic                     w_ge;

    assign w_mag   = i_num[ptc_pkg::PW-1] ? (~i_num + 1'b1) : i_num;
    assign w_trial = {r_rem, r_quo[ptc_pkg::QW-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(ptc_pkg::QW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {{(ptc_pkg::DW-HW){1'b0}}, w_mag[ptc_pkg::PW-1:ptc_pkg::QW]};
            r_quo <= w_mag[ptc_pkg::QW-1:0];
            r_neg <= i_num[ptc_pkg::PW-1];
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[ptc_pkg::DW-1:0] : w_trial[ptc_pkg::DW-1:0];
            r_quo <= {r_quo[ptc_pkg::QW-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_neg  = r_neg;
    assign o_busy = (r_cnt != '0);

endmodule

`default_nettype wire

/* rtl/core/pid_temperature_controller.sv */
// One channel of a PID temperature controller with an integrator clamp.
// Input channel (i_in_valid, o_in_ready, i_in_data) carries the measured
// temperature in millikelvin and the milliseconds since the last sample.
// Output channel (o_out_valid, i_out_ready, o_out_data) returns the drive
// command, saturated to 32 bits, and the in-window flag; one result per input.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while
// the block is idle; writes take effect at once.
// One item is handled at a time. Between the input transfer and a valid
// result the block runs up to seven shift-and-add multiplies on one shared
// unit and a 38-step restoring divide.
// The result sits in an output register, so the next input is taken while
// it waits; if the receiver stalls and a second result is ready, the block
// holds it and accepts no new input until the output register frees up.
// Reset clears the integral and previous error, sets the gains, setpoint and
// window to zero and the integral limit to 15000, and empties the output.
`default_nettype none
`include "pid_temperature_controller_defines.svh"

module pid_temperature_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire ptc_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output ptc_pkg::t_out_item                 o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptc_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  wire logic [ptc_pkg::CFG_DW-1:0]    i_cfg_data
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_INT   = 12'b0000_0000_0010,
        ST_SAT   = 12'b0000_0000_0100,
        ST_LIM   = 12'b0000_0000_1000,
        ST_CLAMP = 12'b0000_0001_0000,
        ST_PROP  = 12'b0000_0010_0000,
        ST_KSC   = 12'b0000_0100_0000,
        ST_INTG  = 12'b0000_1000_0000,
        ST_TSC   = 12'b0001_0000_0000,
        ST_DER   = 12'b0010_0000_0000,
        ST_DIV   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } t_state;

    localparam int PW = ptc_pkg::PW;
    localparam int YW = ptc_pkg::YW;
    localparam int DW = ptc_pkg::DW;
    localparam int QW = ptc_pkg::QW;

    logic signed [20:0]  r_setpoint;
    logic signed [15:0]  r_gain_p;
    logic signed [15:0]  r_gain_i;
    logic signed [15:0]  r_gain_d;
    logic        [15:0]  r_window;
    logic        [15:0]  r_limit;

    t_state              r_state;
    t_state              n_state;
    logic                r_ld;
    logic                n_ld;
    logic                r_out_valid;
    logic                n_out_valid;
    ptc_pkg::t_out_item  r_out;

    logic signed [21:0]  r_prev;
    logic signed [31:0]  r_integ;
    logic signed [31:0]  r_acc;
    logic signed [21:0]  r_err;
    logic signed [22:0]  r_derr;
    logic        [15:0]  r_dt;
    logic                r_win;
    logic        [DW-1:0] r_den;

    logic                w_accept;
    logic signed [21:0]  w_err;
    logic signed [22:0]  w_derr;
    logic        [21:0]  w_err_mag;
    logic        [15:0]  w_dte;
    logic        [15:0]  w_abs_gp;
    logic        [15:0]  w_abs_gi;
    logic        [15:0]  w_abs_gd;
    logic signed [43:0]  w_derr_sc;
    logic        [DW-1:0] w_den;
    logic signed [38:0]  w_isum;
    logic signed [31:0]  w_isat;
    logic signed [32:0]  w_lim_pos;
    logic signed [32:0]  w_lim_neg;
    logic signed [31:0]  w_iclamp;
    logic        [31:0]  w_drive;
    logic                w_clamp_on;
    logic                w_integ_in;

    ptc_pkg::t_mul_ctl   w_mul_ctl;
    logic [PW-1:0]       w_mcand;
    logic [YW-1:0]       w_mplier;
    logic [PW-1:0]       w_prod;
    logic                w_mul_busy;
    logic                w_div_start;
    logic [QW-1:0]       w_quo;
    logic                w_quo_neg;
    logic                w_div_busy;
    logic                w_is_mul;
    logic                w_is_div;
    t_state              w_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_window   <= '0;
            r_limit    <= 16'(ptc_pkg::LIMIT_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptc_pkg::CFG_SETPOINT: r_setpoint <= i_cfg_data;
                ptc_pkg::CFG_GAIN_P:   r_gain_p   <= i_cfg_data[15:0];
                ptc_pkg::CFG_GAIN_I:   r_gain_i   <= i_cfg_data[15:0];
                ptc_pkg::CFG_GAIN_D:   r_gain_d   <= i_cfg_data[15:0];
                ptc_pkg::CFG_WINDOW:   r_window   <= i_cfg_data[15:0];
                ptc_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_err     = {r_setpoint[20], r_setpoint}
                     - {i_in_data.measured_temp[20], i_in_data.measured_temp};
    assign w_derr    = {w_err[21], w_err} - {r_prev[21], r_prev};
    assign w_err_mag = w_err[21] ? (~w_err + 1'b1) : w_err;

    assign w_dte     = (r_dt == '0) ? 16'd1 : r_dt;
    assign w_abs_gp  = r_gain_p[15] ? (~r_gain_p + 1'b1) : r_gain_p;
    assign w_abs_gi  = r_gain_i[15] ? (~r_gain_i + 1'b1) : r_gain_i;
    assign w_abs_gd  = r_gain_d[15] ? (~r_gain_d + 1'b1) : r_gain_d;
    assign w_derr_sc = $signed({{21{r_derr[22]}}, r_derr}) * $signed(44'(ptc_pkg::I_SCALE));
    assign w_den     = {{(DW-16){1'b0}}, w_dte} * DW'(ptc_pkg::I_SCALE);

    assign w_isum    = $signed({{7{r_integ[31]}}, r_integ}) + $signed(w_prod[38:0]);
    assign w_isat    = (w_isum[38:31] == {8{w_isum[38]}}) ? w_isum[31:0]
                     : (w_isum[38] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign w_lim_pos = $signed({1'b0, w_prod[31:0]});
    assign w_lim_neg = -w_lim_pos;

    always_comb begin
        w_iclamp = r_acc;
        if (r_gain_i != '0) begin
            if (r_acc > w_lim_pos) begin
                w_iclamp = w_lim_pos[31:0];
            end else if (r_acc < w_lim_neg) begin
                w_iclamp = w_lim_neg[31:0];
            end
        end
    end

    always_comb begin
        if (w_quo_neg) begin
            if ((|w_quo[QW-1:32]) || (w_quo[31] && (|w_quo[30:0]))) begin
                w_drive = 32'h8000_0000;
            end else begin
                w_drive = ~w_quo[31:0] + 1'b1;
            end
        end else begin
            if (|w_quo[QW-1:31]) begin
                w_drive = 32'h7FFF_FFFF;
            end else begin
                w_drive = w_quo[31:0];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ld        = r_ld;
        n_out_valid = r_out_valid && !i_out_ready;
        w_mul_ctl   = '{load: 1'b0, clr: 1'b1, sub: 1'b0};
        w_mcand     = '0;
        w_mplier    = '0;
        w_div_start = 1'b0;
        w_is_mul    = 1'b0;
        w_is_div    = 1'b0;
        w_after     = ST_IDLE;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_INT;
                    n_ld    = 1'b1;
                end
            end
            ST_INT: begin
                w_is_mul = 1'b1;
                w_after  = ST_SAT;
                w_mcand  = {{(PW-22){r_err[21]}}, r_err};
                w_mplier = r_dt;
            end
            ST_SAT: begin
                n_state = ST_LIM;
                n_ld    = 1'b1;
            end
            ST_LIM: begin
                w_is_mul = 1'b1;
                w_after  = ST_CLAMP;
                w_mcand  = {{(PW-16){1'b0}}, r_limit};
                w_mplier = w_abs_gi;
            end
            ST_CLAMP: begin
                n_state = ST_PROP;
                n_ld    = 1'b1;
            end
            ST_PROP: begin
                w_is_mul      = 1'b1;
                w_after       = ST_KSC;
                w_mcand       = {{(PW-22){r_err[21]}}, r_err};
                w_mplier      = w_abs_gp;
                w_mul_ctl.sub = r_gain_p[15];
            end
            ST_KSC: begin
                w_is_mul = 1'b1;
                w_after  = ST_INTG;
                w_mcand  = w_prod;
                w_mplier = YW'(ptc_pkg::P_SCALE);
            end
            ST_INTG: begin
                w_is_mul      = 1'b1;
                w_after       = ST_TSC;
                w_mcand       = {{(PW-32){r_acc[31]}}, r_acc};
                w_mplier      = w_abs_gi;
                w_mul_ctl.sub = r_gain_i[15];
                w_mul_ctl.clr = 1'b0;
            end
            ST_TSC: begin
                w_is_mul = 1'b1;
                w_after  = (r_dt != '0) ? ST_DER : ST_DIV;
                w_mcand  = w_prod;
                w_mplier = w_dte;
            end
            ST_DER: begin
                w_is_mul      = 1'b1;
                w_after       = ST_DIV;
                w_mcand       = {{(PW-44){w_derr_sc[43]}}, w_derr_sc};
                w_mplier      = w_abs_gd;
                w_mul_ctl.sub = r_gain_d[15];
                w_mul_ctl.clr = 1'b0;
            end
            ST_DIV: begin
                w_is_div = 1'b1;
                w_after  = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_is_mul || w_is_div) begin
            if (r_ld) begin
                w_mul_ctl.load = w_is_mul;
                w_div_start    = w_is_div;
                n_ld           = 1'b0;
            end else if (!(w_is_mul ? w_mul_busy : w_div_busy)) begin
                n_state = w_after;
                n_ld    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ld        <= 1'b1;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_integ     <= '0;
        end else begin
            r_state     <= n_state;
            r_ld        <= n_ld;
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_prev <= w_err;
            end
            if (r_state == ST_CLAMP) begin
                r_integ <= w_iclamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err  <= w_err;
            r_derr <= w_derr;
            r_dt   <= i_in_data.elapsed_ms;
            r_win  <= (w_err_mag < {6'd0, r_window});
        end
        if (r_state == ST_SAT) begin
            r_acc <= w_isat;
            r_den <= w_den;
        end
        if (r_state == ST_CLAMP) begin
            r_acc <= w_iclamp;
        end
        if ((r_state == ST_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out.drive     <= w_drive;
            r_out.in_window <= r_win;
        end
    end

    ptc_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_prod   (w_prod),
        .o_busy   (w_mul_busy)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_den),
        .o_quo   (w_quo),
        .o_neg   (w_quo_neg),
        .o_busy  (w_div_busy)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_clamp_on = (r_state == ST_CLAMP) && (r_gain_i != 16'sd0);
    assign w_integ_in = (r_integ <= w_lim_pos) && (r_integ >= w_lim_neg);

    `PTC_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == ST_INT)
    `PTC_ASSERT_IMP(a_mul_load_idle, i_clk, i_rst_n, w_mul_ctl.load, !w_mul_busy)
    `PTC_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, w_div_start, !w_div_busy && !w_mul_busy)
    `PTC_ASSERT_NXT(a_integral_bound, i_clk, i_rst_n, w_clamp_on, w_integ_in)

endmodule

`default_nettype wire

/* verif/pid_drive_checker.sv */
`timescale 1ns / 100ps

module pid_drive_checker
    import ptc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IW-1:0]    i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_open_count
);

    localparam longint MILLI     = 1000;
    localparam longint MICRO     = 1000000;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    logic signed [20:0] setpoint;
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic        [15:0] window;
    logic        [15:0] int_limit;
    logic signed [21:0] last_err;
    logic signed [31:0] integ;

    t_out_item expected_drives[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic longint clip32(input longint v);
        if (v > DRIVE_MAX) begin
            return DRIVE_MAX;
        end
        if (v < DRIVE_MIN) begin
            return DRIVE_MIN;
        end
        return v;
    endfunction

    // Advances the integral and previous error by one sample and returns the
    // drive and in-window flag that this sample produces.
    function automatic t_out_item predict_drive(input logic signed [20:0] meas,
                                                input logic [15:0] dt_ms);
        longint             err;
        longint             derr;
        longint             dt;
        longint             sum;
        longint             clamp;
        longint             mag;
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] wc;
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] quo;
        longint             drv;
        t_out_item          res;

        dt   = longint'(dt_ms);
        err  = setpoint;
        err  = err - meas;
        derr = last_err;
        derr = err - derr;

        sum = integ;
        sum = clip32(sum + err * dt);
        if (ki != 0) begin
            clamp = ki;
            if (clamp < 0) begin
                clamp = -clamp;
            end
            clamp = clamp * longint'(int_limit);
            if (sum > clamp) begin
                sum = clamp;
            end
            if (sum < -clamp) begin
                sum = -clamp;
            end
        end

        wa = kp * err;
        wb = ki * sum;
        wc = kd * derr;
        if (dt != 0) begin
            num = wa * MILLI * dt + wb * dt + wc * MICRO;
            den = MICRO * dt;
        end else begin
            num = wa * MILLI + wb;
            den = MICRO;
        end
        quo = num / den;
        if (quo > DRIVE_MAX) begin
            drv = DRIVE_MAX;
        end else if (quo < DRIVE_MIN) begin
            drv = DRIVE_MIN;
        end else begin
            drv = longint'(quo);
        end

        mag = (err < 0) ? -err : err;
        res.drive     = drv[31:0];
        res.in_window = (mag < longint'(window));

        integ    = sum[31:0];
        last_err = err[21:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;

        if (!i_rst_n) begin
            setpoint  = '0;
            kp        = '0;
            ki        = '0;
            kd        = '0;
            window    = '0;
            int_limit = 16'(LIMIT_RESET);
            last_err  = '0;
            integ     = '0;
            expected_drives.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SETPOINT: setpoint  = i_cfg_data;
                    CFG_GAIN_P:   kp        = i_cfg_data[15:0];
                    CFG_GAIN_I:   ki        = i_cfg_data[15:0];
                    CFG_GAIN_D:   kd        = i_cfg_data[15:0];
                    CFG_WINDOW:   window    = i_cfg_data[15:0];
                    CFG_LIMIT:    int_limit = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_drives.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding, drive",
                                    i_out_data.drive, 0);
                end else begin
                    want = expected_drives.pop_front();
                    if (i_out_data.drive !== want.drive) begin
                        report_mismatch("drive", i_out_data.drive, want.drive);
                    end
                    if (i_out_data.in_window !== want.in_window) begin
                        report_mismatch("in_window", i_out_data.in_window, want.in_window);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_drives.push_back(predict_drive(i_in_data.measured_temp,
                                                        i_in_data.elapsed_ms));
            end
        end
        o_open_count = expected_drives.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ptc_pkg::*;

    localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;
    localparam int TEMP_MAX      = 1000000;
    localparam int U16_MAX       = 65535;
    localparam int S16_MAX       = 32767;
    localparam int S16_MIN       = -32768;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 200;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in_item            in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    t_out_item           out_data;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_idx = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;
    int                  fail_count;
    int                  open_count;
    int                  send_gap_pct = 0;
    int                  recv_stall_pct = 0;

    pid_temperature_controller DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pid_drive_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #15_000_000;
        $display("pid_temperature_controller test failed");
        $finish;
    end

    initial begin
        forever begin
            @(posedge clk);
            if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic send_sample(input int meas, input int dt);
        in_data.measured_temp <= meas[20:0];
        in_data.elapsed_ms    <= dt[15:0];
        in_valid              <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Holds off the sender until every outstanding result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (open_count == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input int sp, input int gp, input int gi, input int gd,
                                 input int win, input int lim);
        put_reg(CFG_SETPOINT, sp[20:0]);
        put_reg(CFG_GAIN_P, {5'($urandom), gp[15:0]});
        put_reg(CFG_GAIN_I, {5'($urandom), gi[15:0]});
        put_reg(CFG_GAIN_D, {5'($urandom), gd[15:0]});
        put_reg(CFG_WINDOW, {5'($urandom), win[15:0]});
        put_reg(CFG_LIMIT, {5'($urandom), lim[15:0]});
        put_reg(CFG_SPARE_LO, CFG_DW'($urandom));
        put_reg(CFG_SPARE_HI, CFG_DW'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial begin
        int sp;
        int gp;
        int gi;
        int gd;
        int win;
        int lim;
        int temp;
        int step;
        int dt;
        int pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(0, 0);
        send_sample(-TEMP_MAX, U16_MAX);
        drain();
        put_reg(CFG_GAIN_I, 21'd1000);
        cfg_we <= 1'b0;
        send_sample(-TEMP_MAX, U16_MAX);
        send_sample(0, 1);
        drain();

        load_settings(TEMP_MAX, S16_MAX, S16_MIN, S16_MIN, U16_MAX, U16_MAX);
        send_sample(-TEMP_MAX, U16_MAX);
        send_sample(TEMP_MAX, 0);
        send_sample(TEMP_MAX - 10, 1);
        send_sample(TEMP_MAX, 3);
        send_sample(-TEMP_MAX, 0);
        send_sample(0, U16_MAX);
        drain();

        load_settings(-TEMP_MAX, S16_MIN, 0, S16_MAX, 0, 0);
        send_sample(TEMP_MAX, U16_MAX);
        send_sample(TEMP_MAX, U16_MAX);
        send_sample(-TEMP_MAX, 1);
        send_sample(TEMP_MAX, 1);
        send_sample(-TEMP_MAX, 0);
        send_sample(-TEMP_MAX + 1, 2);
        drain();

        load_settings(-5, 7, 3, 1, 1, 0);
        send_sample(-5, 10);
        send_sample(-4, 10);
        send_sample(-6, 0);
        drain();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == 0) begin
                sp  = $urandom_range(0, 1) ? TEMP_MAX : -TEMP_MAX;
                gp  = $urandom_range(0, 1) ? S16_MAX : S16_MIN;
                gi  = $urandom_range(0, 1) ? S16_MAX : S16_MIN;
                gd  = $urandom_range(0, 1) ? S16_MAX : S16_MIN;
                win = U16_MAX;
                lim = U16_MAX;
            end else if (phase == 1) begin
                sp  = rand_between(-TEMP_MAX, TEMP_MAX);
                gp  = rand_between(S16_MIN, S16_MAX);
                gi  = rand_between(S16_MIN, S16_MAX);
                gd  = rand_between(S16_MIN, S16_MAX);
                win = 0;
                lim = 0;
            end else begin
                sp  = rand_between(-TEMP_MAX, TEMP_MAX);
                gp  = rand_between(S16_MIN, S16_MAX);
                gi  = ($urandom_range(0, 3) == 0) ? 0 : rand_between(S16_MIN, S16_MAX);
                gd  = ($urandom_range(0, 3) == 0) ? 0 : rand_between(S16_MIN, S16_MAX);
                win = $urandom_range(0, 1) ? rand_between(0, 2000) : rand_between(0, U16_MAX);
                lim = rand_between(0, U16_MAX);
            end
            load_settings(sp, gp, gi, gd, win, lim);

            if (phase >= RAND_PHASES - 2 || phase == 3) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end else begin
                send_gap_pct   = rand_between(5, 40);
                recv_stall_pct = rand_between(5, 40);
            end

            // Most samples follow a slow drift around the setpoint, as a real
            // loop would see; the rest jump anywhere from -TEMP_MAX to TEMP_MAX.
            step = rand_between(10, 5000);
            temp = sp + rand_between(-step, step);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    temp = rand_between(-TEMP_MAX, TEMP_MAX);
                end else begin
                    temp = temp + rand_between(-step, step);
                end
                if (temp > TEMP_MAX) begin
                    temp = TEMP_MAX;
                end
                if (temp < -TEMP_MAX) begin
                    temp = -TEMP_MAX;
                end
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    dt = 0;
                end else if (pick < 85) begin
                    dt = rand_between(1, 250);
                end else begin
                    dt = rand_between(0, U16_MAX);
                end
                send_sample(temp, dt);
                if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1) begin
                    drain();
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && open_count == 0) begin
            $display("pid_temperature_controller test passed");
        end else begin
            $display("pid_temperature_controller test failed");
        end
        $finish;
    end

endmodule
